// ===== hdl/usbcep_pkg.sv =====
`default_nettype none
package usbcep_pkg;

    localparam int MAX_PACKET = 64;

    localparam logic [1:0] EVT_BUS_RESET = 2'd0;
    localparam logic [1:0] EVT_SETUP     = 2'd1;
    localparam logic [1:0] EVT_IN_DONE   = 2'd2;
    localparam logic [1:0] EVT_OUT_DONE  = 2'd3;

    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

    localparam logic [7:0] DT_DEVICE    = 8'd1;
    localparam logic [7:0] DT_CONFIG    = 8'd2;
    localparam logic [7:0] DT_STRING    = 8'd3;
    localparam logic [7:0] DT_QUALIFIER = 8'd6;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_SETADDR = 3'd1;
    localparam logic [2:0] ACT_SETCONF = 3'd2;
    localparam logic [2:0] ACT_DATA    = 3'd3;
    localparam logic [2:0] ACT_STATUS  = 3'd4;

    localparam logic [1:0] SEND_NONE  = 2'd0;
    localparam logic [1:0] SEND_ZLP   = 2'd1;
    localparam logic [1:0] SEND_CHUNK = 2'd2;

    localparam logic [2:0] TBL_DEVICE = 3'd0;
    localparam logic [2:0] TBL_CONFIG = 3'd1;
    localparam logic [2:0] TBL_LANG   = 3'd2;

    localparam logic [1:0] CFG_LANG_LEN    = 2'd0;
    localparam logic [1:0] CFG_VENDOR_LEN  = 2'd1;
    localparam logic [1:0] CFG_PRODUCT_LEN = 2'd2;
    localparam logic [1:0] CFG_SERIAL_LEN  = 2'd3;

    localparam logic [7:0] LANG_LEN_RESET    = 8'd4;
    localparam logic [7:0] VENDOR_LEN_RESET  = 8'd38;
    localparam logic [7:0] PRODUCT_LEN_RESET = 8'd50;
    localparam logic [7:0] SERIAL_LEN_RESET  = 8'd26;

    typedef struct packed {
        logic [2:0]  in_action;
        logic        out_rearm;
        logic [15:0] bytes_remaining;
        logic [15:0] read_offset;
        logic [2:0]  active_table;
        logic        toggle_bit;
        logic [7:0]  pending_address;
        logic [7:0]  device_address;
        logic [7:0]  config_value;
    } state_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  request_code;
        logic [7:0]  value_low;
        logic [7:0]  value_high;
        logic [15:0] request_length;
    } event_t;

    typedef struct packed {
        logic        arm_endpoint;
        logic [1:0]  send_kind;
        logic [2:0]  table_select;
        logic [15:0] chunk_offset;
        logic [6:0]  chunk_length;
        logic        data_toggle;
        logic [7:0]  current_address;
        logic        address_updated;
        logic [7:0]  configuration;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/usb_control_endpoint_sequencer_core.sv =====
// an accepted event's result is registered and shown on the m_ side in the next cycle
// throughput: one event per cycle while m_ready holds, the output register frees as it is taken
// each event is decoded against the sequencer state in a single pass
// reset (aresetn low, synchronous): no pending action, address, configuration
// and toggle cleared, string lengths back to their default values
`default_nettype none
module usb_control_endpoint_sequencer_core #(
    parameter int MAX_PACKET_LEN = usbcep_pkg::MAX_PACKET
) (
    input  var logic        aclk,
    input  var logic        aresetn,

    input  var logic        cfg_we,
    input  var logic [1:0]  cfg_index,
    input  var logic [7:0]  cfg_data,

    input  var logic        s_valid,
    output logic            s_ready,
    input  var logic [1:0]  s_event_kind,
    input  var logic [7:0]  s_request_code,
    input  var logic [7:0]  s_value_low,
    input  var logic [7:0]  s_value_high,
    input  var logic [15:0] s_request_length,

    output logic            m_valid,
    input  var logic        m_ready,
    output logic            m_arm_endpoint,
    output logic [1:0]      m_send_kind,
    output logic [2:0]      m_table_select,
    output logic [15:0]     m_chunk_offset,
    output logic [6:0]      m_chunk_length,
    output logic            m_data_toggle,
    output logic [7:0]      m_current_address,
    output logic            m_address_updated,
    output logic [7:0]      m_configuration
);
    import usbcep_pkg::*;

    state_t          state_reg;
    state_t          state_next;
    event_t          evt;
    result_t         result_next;
    result_t         result_reg;
    logic            m_valid_reg;
    logic [3:0][7:0] string_len_reg;
    logic            accept;

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    assign evt.event_kind     = s_event_kind;
    assign evt.request_code   = s_request_code;
    assign evt.value_low      = s_value_low;
    assign evt.value_high     = s_value_high;
    assign evt.request_length = s_request_length;

    usbcep_step #(
        .MAX_PACKET_LEN (MAX_PACKET_LEN)
    ) u_step (
        .state      (state_reg),
        .evt        (evt),
        .string_len (string_len_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            string_len_reg[CFG_LANG_LEN]    <= LANG_LEN_RESET;
            string_len_reg[CFG_VENDOR_LEN]  <= VENDOR_LEN_RESET;
            string_len_reg[CFG_PRODUCT_LEN] <= PRODUCT_LEN_RESET;
            string_len_reg[CFG_SERIAL_LEN]  <= SERIAL_LEN_RESET;
        end else if (cfg_we) begin
            string_len_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_arm_endpoint    = result_reg.arm_endpoint;
    assign m_send_kind       = result_reg.send_kind;
    assign m_table_select    = result_reg.table_select;
    assign m_chunk_offset    = result_reg.chunk_offset;
    assign m_chunk_length    = result_reg.chunk_length;
    assign m_data_toggle     = result_reg.data_toggle;
    assign m_current_address = result_reg.current_address;
    assign m_address_updated = result_reg.address_updated;
    assign m_configuration   = result_reg.configuration;

endmodule
`default_nettype wire

// ===== hdl/usbcep_step.sv =====
`default_nettype none
module usbcep_step #(
    parameter int MAX_PACKET_LEN = usbcep_pkg::MAX_PACKET
) (
    input  var usbcep_pkg::state_t          state,
    input  var usbcep_pkg::event_t          evt,
    input  var logic [3:0][7:0]             string_len,
    output usbcep_pkg::state_t              state_next,
    output usbcep_pkg::result_t             result
);
    import usbcep_pkg::*;

    localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET_LEN);

    logic        plan_en;
    logic [15:0] plan_rem;
    logic [15:0] plan_off;
    logic [2:0]  plan_table;
    logic        plan_tog;
    logic [6:0]  chunk_len;
    logic [15:0] rest;

    always_comb begin
        plan_en    = 1'b0;
        plan_rem   = state.bytes_remaining;
        plan_off   = state.read_offset;
        plan_table = state.active_table;
        plan_tog   = state.toggle_bit;
        state_next = state;
        result     = '0;

        case (evt.event_kind)
            EVT_BUS_RESET: begin
                state_next.toggle_bit = 1'b0;
            end
            EVT_SETUP: begin
                if (evt.request_code == REQ_SET_CONFIGURATION) begin
                    state_next.config_value = evt.value_low;
                    state_next.toggle_bit   = 1'b1;
                    state_next.in_action    = ACT_SETCONF;
                    result.send_kind        = SEND_ZLP;
                    result.data_toggle      = 1'b1;
                    result.arm_endpoint     = 1'b1;
                end else if (evt.request_code == REQ_SET_ADDRESS) begin
                    state_next.pending_address = evt.value_low;
                    state_next.toggle_bit      = 1'b1;
                    state_next.in_action       = ACT_SETADDR;
                    result.send_kind           = SEND_ZLP;
                    result.data_toggle         = 1'b1;
                    result.arm_endpoint        = 1'b1;
                end else if (evt.request_code == REQ_GET_DESCRIPTOR) begin
                    plan_off = '0;
                    plan_tog = 1'b0;
                    if (evt.value_high == DT_DEVICE) begin
                        plan_en    = 1'b1;
                        plan_table = TBL_DEVICE;
                        plan_rem   = evt.request_length;
                    end else if (evt.value_high == DT_CONFIG) begin
                        plan_en    = 1'b1;
                        plan_table = TBL_CONFIG;
                        plan_rem   = evt.request_length;
                    end else if (evt.value_high == DT_QUALIFIER) begin
                        state_next.toggle_bit = 1'b1;
                        state_next.in_action  = ACT_STATUS;
                        result.send_kind      = SEND_ZLP;
                        result.data_toggle    = 1'b1;
                        result.arm_endpoint   = 1'b1;
                    end else if (evt.value_high == DT_STRING && evt.value_low[7:2] == 6'd0) begin
                        plan_en    = 1'b1;
                        plan_table = TBL_LANG + {1'b0, evt.value_low[1:0]};
                        plan_rem   = {8'd0, string_len[evt.value_low[1:0]]};
                    end
                end
            end
            EVT_IN_DONE: begin
                case (state.in_action)
                    ACT_SETADDR: begin
                        state_next.device_address = state.pending_address;
                        state_next.in_action      = ACT_NONE;
                        result.address_updated    = 1'b1;
                        result.arm_endpoint       = 1'b1;
                    end
                    ACT_SETCONF: begin
                        state_next.in_action = ACT_NONE;
                        result.arm_endpoint  = 1'b1;
                    end
                    ACT_DATA: begin
                        plan_en = 1'b1;
                    end
                    ACT_STATUS: begin
                        state_next.in_action = ACT_NONE;
                        state_next.out_rearm = 1'b1;
                        result.arm_endpoint  = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                result.arm_endpoint = state.out_rearm;
            end
        endcase

        chunk_len = (plan_rem > MAX_LEN) ? MAX_LEN[6:0] : plan_rem[6:0];
        rest      = plan_rem - {9'd0, chunk_len};

        if (plan_en) begin
            state_next.active_table    = plan_table;
            state_next.bytes_remaining = rest;
            state_next.toggle_bit      = plan_tog;
            state_next.read_offset     = plan_off;
            if (chunk_len != 7'd0) begin
                state_next.toggle_bit = ~plan_tog;
                result.arm_endpoint   = 1'b1;
                result.send_kind      = SEND_CHUNK;
                result.table_select   = plan_table;
                result.chunk_offset   = plan_off;
                result.chunk_length   = chunk_len;
                result.data_toggle    = ~plan_tog;
            end
            if (rest != 16'd0) begin
                state_next.read_offset = plan_off + {9'd0, chunk_len};
                state_next.in_action   = ACT_DATA;
            end else begin
                state_next.in_action = ACT_STATUS;
            end
        end

        result.current_address = state_next.device_address;
        result.configuration   = state_next.config_value;
    end

endmodule
`default_nettype wire

// ===== tb/usb_control_endpoint_sequencer_core_tb.sv =====
`default_nettype none
module usb_control_endpoint_sequencer_core_tb;
    import usbcep_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_EVENTS = 200;
    localparam result_t NO_RESULT = '0;

    typedef struct packed {
        event_t  ev;
        logic    typed;
        result_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_event_kind = 2'd0;
    logic [7:0]  s_request_code = 8'd0;
    logic [7:0]  s_value_low = 8'd0;
    logic [7:0]  s_value_high = 8'd0;
    logic [15:0] s_request_length = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_arm_endpoint;
    logic [1:0]  m_send_kind;
    logic [2:0]  m_table_select;
    logic [15:0] m_chunk_offset;
    logic [6:0]  m_chunk_length;
    logic        m_data_toggle;
    logic [7:0]  m_current_address;
    logic        m_address_updated;
    logic [7:0]  m_configuration;

    state_t     ep0_state;
    logic [7:0] string_len [4];
    result_t    expected_results [$];
    dir_row_t   dir_tab [$];
    result_t    want;
    result_t    got;
    bit         mismatch_seen = 1'b0;
    bit         idle_on = 1'b1;
    int         acted_count = 0;
    int         stall_cycles = 0;

    usb_control_endpoint_sequencer_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_event_kind      (s_event_kind),
        .s_request_code    (s_request_code),
        .s_value_low       (s_value_low),
        .s_value_high      (s_value_high),
        .s_request_length  (s_request_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_arm_endpoint    (m_arm_endpoint),
        .m_send_kind       (m_send_kind),
        .m_table_select    (m_table_select),
        .m_chunk_offset    (m_chunk_offset),
        .m_chunk_length    (m_chunk_length),
        .m_data_toggle     (m_data_toggle),
        .m_current_address (m_current_address),
        .m_address_updated (m_address_updated),
        .m_configuration   (m_configuration)
    );

    always #2 aclk = ~aclk;

    function automatic result_t status_result(input logic arm, input logic [1:0] kind,
                                              input logic tog, input logic [7:0] addr,
                                              input logic upd, input logic [7:0] conf);
        result_t r;
        r = '0;
        r.arm_endpoint = arm;
        r.send_kind = kind;
        r.data_toggle = tog;
        r.current_address = addr;
        r.address_updated = upd;
        r.configuration = conf;
        return r;
    endfunction

    function automatic event_t random_event();
        event_t e;
        e.event_kind = 2'($urandom);
        e.request_code = 8'($urandom);
        e.value_low = 8'($urandom);
        e.value_high = 8'($urandom);
        e.request_length = 16'($urandom);
        return e;
    endfunction

    task automatic queue_zlp(inout result_t r);
        ep0_state.toggle_bit = 1'b1;
        r.send_kind = SEND_ZLP;
        r.data_toggle = 1'b1;
        r.arm_endpoint = 1'b1;
    endtask

    // next chunk of the active descriptor, or the status plan once it is used up
    task automatic queue_chunk(inout result_t r);
        logic [15:0] take;
        take = (ep0_state.bytes_remaining > 16'(MAX_PACKET)) ? 16'(MAX_PACKET)
                                                              : ep0_state.bytes_remaining;
        if (take != 16'd0) begin
            ep0_state.toggle_bit = ~ep0_state.toggle_bit;
            r.arm_endpoint = 1'b1;
            r.send_kind = SEND_CHUNK;
            r.table_select = ep0_state.active_table;
            r.chunk_offset = ep0_state.read_offset;
            r.chunk_length = take[6:0];
            r.data_toggle = ep0_state.toggle_bit;
        end
        ep0_state.bytes_remaining = ep0_state.bytes_remaining - take;
        if (ep0_state.bytes_remaining != 16'd0) begin
            ep0_state.read_offset = ep0_state.read_offset + take;
            ep0_state.in_action = ACT_DATA;
        end else begin
            ep0_state.in_action = ACT_STATUS;
        end
    endtask

    task automatic step_sequencer(input event_t e, output result_t r, output bit acted);
        logic [2:0]  tbl;
        logic [15:0] len;
        bit          go;
        r = '0;
        acted = 1'b0;
        tbl = TBL_DEVICE;
        len = 16'd0;
        go = 1'b0;
        case (e.event_kind)
            EVT_BUS_RESET: begin
                ep0_state.toggle_bit = 1'b0;
                acted = 1'b1;
            end
            EVT_SETUP: begin
                case (e.request_code)
                    REQ_SET_CONFIGURATION: begin
                        ep0_state.config_value = e.value_low;
                        queue_zlp(r);
                        ep0_state.in_action = ACT_SETCONF;
                        acted = 1'b1;
                    end
                    REQ_SET_ADDRESS: begin
                        ep0_state.pending_address = e.value_low;
                        queue_zlp(r);
                        ep0_state.in_action = ACT_SETADDR;
                        acted = 1'b1;
                    end
                    REQ_GET_DESCRIPTOR: begin
                        if (e.value_high == DT_DEVICE) begin
                            tbl = TBL_DEVICE;
                            len = e.request_length;
                            go = 1'b1;
                        end else if (e.value_high == DT_CONFIG) begin
                            tbl = TBL_CONFIG;
                            len = e.request_length;
                            go = 1'b1;
                        end else if (e.value_high == DT_QUALIFIER) begin
                            queue_zlp(r);
                            ep0_state.in_action = ACT_STATUS;
                            acted = 1'b1;
                        end else if (e.value_high == DT_STRING && e.value_low < 8'd4) begin
                            tbl = TBL_LANG + {1'b0, e.value_low[1:0]};
                            len = {8'h00, string_len[e.value_low[1:0]]};
                            go = 1'b1;
                        end
                        if (go) begin
                            ep0_state.active_table = tbl;
                            ep0_state.bytes_remaining = len;
                            ep0_state.read_offset = 16'd0;
                            ep0_state.toggle_bit = 1'b0;
                            queue_chunk(r);
                            acted = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            EVT_IN_DONE: begin
                acted = ep0_state.in_action != ACT_NONE && ep0_state.in_action <= ACT_STATUS;
                case (ep0_state.in_action)
                    ACT_SETADDR: begin
                        ep0_state.device_address = ep0_state.pending_address;
                        r.address_updated = 1'b1;
                        r.arm_endpoint = 1'b1;
                        ep0_state.in_action = ACT_NONE;
                    end
                    ACT_SETCONF: begin
                        r.arm_endpoint = 1'b1;
                        ep0_state.in_action = ACT_NONE;
                    end
                    ACT_DATA: queue_chunk(r);
                    ACT_STATUS: begin
                        r.arm_endpoint = 1'b1;
                        ep0_state.in_action = ACT_NONE;
                        ep0_state.out_rearm = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: begin
                if (ep0_state.out_rearm) begin
                    r.arm_endpoint = 1'b1;
                    acted = 1'b1;
                end
            end
        endcase
        r.current_address = ep0_state.device_address;
        r.configuration = ep0_state.config_value;
    endtask

    task automatic send_event(input event_t e, input bit typed, input result_t typed_res);
        result_t pred;
        bit      acted;
        while (idle_on && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_event_kind, s_request_code, s_value_low, s_value_high, s_request_length} <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_sequencer(e, pred, acted);
        expected_results.push_back(typed ? typed_res : pred);
        if (acted) acted_count++;
    endtask

    task automatic write_len(input logic [1:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        string_len[idx] = val;
    endtask

    function automatic event_t random_setup();
        event_t e;
        int     sel;
        e = random_event();
        e.event_kind = EVT_SETUP;
        sel = $urandom_range(99);
        if (sel < 12) e.request_code = REQ_SET_ADDRESS;
        else if (sel < 24) e.request_code = REQ_SET_CONFIGURATION;
        else if (sel < 92) e.request_code = REQ_GET_DESCRIPTOR;
        if (e.request_code == REQ_GET_DESCRIPTOR) begin
            sel = $urandom_range(99);
            if (sel < 25) e.value_high = DT_DEVICE;
            else if (sel < 50) e.value_high = DT_CONFIG;
            else if (sel < 85) e.value_high = DT_STRING;
            else if (sel < 95) e.value_high = DT_QUALIFIER;
            if ($urandom_range(99) < 90) e.value_low = 8'($urandom_range(3));
        end
        sel = $urandom_range(99);
        if (sel < 70) e.request_length = 16'($urandom_range(200));
        else if (sel < 95) e.request_length = 16'($urandom_range(1024));
        return e;
    endfunction

    // mostly complete control transfers, with noise and cut-short transfers mixed in
    task automatic drive_random_phase(input int target);
        event_t e;
        int     n;
        int     cap;
        acted_count = 0;
        while (acted_count < target) begin
            if ($urandom_range(99) < 25) begin
                send_event(random_event(), 1'b0, NO_RESULT);
            end else begin
                send_event(random_setup(), 1'b0, NO_RESULT);
                cap = ($urandom_range(99) < 15) ? $urandom_range(3) : 40;
                n = 0;
                while (ep0_state.in_action != ACT_NONE && n < cap) begin
                    e = random_event();
                    e.event_kind = ($urandom_range(99) < 6) ? EVT_BUS_RESET : EVT_IN_DONE;
                    send_event(e, 1'b0, NO_RESULT);
                    n++;
                end
                if ($urandom_range(99) < 70) begin
                    e = random_event();
                    e.event_kind = EVT_OUT_DONE;
                    send_event(e, 1'b0, NO_RESULT);
                end
            end
        end
    endtask

    task automatic check_field(input string fname, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, fname, want_v, got_v);
            mismatch_seen = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 19);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got = {m_arm_endpoint, m_send_kind, m_table_select, m_chunk_offset,
                   m_chunk_length, m_data_toggle, m_current_address, m_address_updated,
                   m_configuration};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transaction on result side", $time);
                mismatch_seen = 1'b1;
            end else begin
                want = expected_results.pop_front();
                check_field("arm_endpoint", 16'(want.arm_endpoint), 16'(got.arm_endpoint));
                check_field("send_kind", 16'(want.send_kind), 16'(got.send_kind));
                check_field("table_select", 16'(want.table_select), 16'(got.table_select));
                check_field("chunk_offset", want.chunk_offset, got.chunk_offset);
                check_field("chunk_length", 16'(want.chunk_length), 16'(got.chunk_length));
                check_field("data_toggle", 16'(want.data_toggle), 16'(got.data_toggle));
                check_field("current_address", 16'(want.current_address),
                            16'(got.current_address));
                check_field("address_updated", 16'(want.address_updated),
                            16'(got.address_updated));
                check_field("configuration", 16'(want.configuration), 16'(got.configuration));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : main_seq
        logic [7:0] lens [4];
        ep0_state = '0;
        string_len[CFG_LANG_LEN] = LANG_LEN_RESET;
        string_len[CFG_VENDOR_LEN] = VENDOR_LEN_RESET;
        string_len[CFG_PRODUCT_LEN] = PRODUCT_LEN_RESET;
        string_len[CFG_SERIAL_LEN] = SERIAL_LEN_RESET;

        dir_tab.push_back({{EVT_OUT_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h00, 1'b0, 8'h00)});
        dir_tab.push_back({{EVT_IN_DONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h00, 1'b0, 8'h00)});
        dir_tab.push_back({{EVT_BUS_RESET, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h00, 1'b0, 8'h00)});
        // unknown request, unknown descriptor type, string index out of range
        dir_tab.push_back({{EVT_SETUP, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h00, 1'b0, 8'h00)});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h00, 8'h07, 16'h0040}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h00, 1'b0, 8'h00)});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h04, DT_STRING, 16'h00FF}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h00, 1'b0, 8'h00)});
        dir_tab.push_back({{EVT_SETUP, REQ_SET_CONFIGURATION, 8'hFF, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b1, SEND_ZLP, 1'b1, 8'h00, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_IN_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b1, SEND_NONE, 1'b0, 8'h00, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_SETUP, REQ_SET_ADDRESS, 8'h7F, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b1, SEND_ZLP, 1'b1, 8'h00, 1'b0, 8'hFF)});
        // bus reset keeps the pending address change
        dir_tab.push_back({{EVT_BUS_RESET, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h00, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_IN_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b1, SEND_NONE, 1'b0, 8'h7F, 1'b1, 8'hFF)});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h00, DT_DEVICE, 16'hFFFF}, 1'b0,
            NO_RESULT});
        dir_tab.push_back({{EVT_IN_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b0, NO_RESULT});
        dir_tab.push_back({{EVT_BUS_RESET, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h7F, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_IN_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b0, NO_RESULT});
        // zero length transfer goes straight to the status stage
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h00, DT_CONFIG, 16'h0000}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h7F, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_OUT_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b0, SEND_NONE, 1'b0, 8'h7F, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_IN_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
            status_result(1'b1, SEND_NONE, 1'b0, 8'h7F, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_OUT_DONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1,
            status_result(1'b1, SEND_NONE, 1'b0, 8'h7F, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h00, DT_QUALIFIER, 16'h000A}, 1'b1,
            status_result(1'b1, SEND_ZLP, 1'b1, 8'h7F, 1'b0, 8'hFF)});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h00, DT_STRING, 16'h0040}, 1'b0,
            NO_RESULT});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h01, DT_STRING, 16'h0001}, 1'b0,
            NO_RESULT});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h02, DT_STRING, 16'h0000}, 1'b0,
            NO_RESULT});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h03, DT_STRING, 16'hFFFF}, 1'b0,
            NO_RESULT});
        dir_tab.push_back({{EVT_SETUP, REQ_GET_DESCRIPTOR, 8'h00, DT_CONFIG, 16'h0041}, 1'b0,
            NO_RESULT});
        dir_tab.push_back({{EVT_IN_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b0, NO_RESULT});
        dir_tab.push_back({{EVT_IN_DONE, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b0, NO_RESULT});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) send_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].res);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: lens = '{8'd0, 8'd0, 8'd0, 8'd0};
                1: lens = '{8'd255, 8'd255, 8'd255, 8'd255};
                2: lens = '{8'd64, 8'd65, 8'd63, 8'd128};
                3: lens = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
                default: lens = '{8'd1, 8'd127, 8'd192, 8'd0};
            endcase
            write_len(CFG_LANG_LEN, lens[CFG_LANG_LEN]);
            write_len(CFG_VENDOR_LEN, lens[CFG_VENDOR_LEN]);
            write_len(CFG_PRODUCT_LEN, lens[CFG_PRODUCT_LEN]);
            write_len(CFG_SERIAL_LEN, lens[CFG_SERIAL_LEN]);
            cfg_we <= 1'b0;
            // one full phase runs back to back on both sides
            idle_on = (p != 2);
            drive_random_phase(PHASE_EVENTS);
            s_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge aclk);
        end

        repeat (4) @(posedge aclk);
        if (mismatch_seen) begin
            $display("Some tests failed");
        end else begin
            $display("All tests passed");
        end
        $finish;
    end

endmodule
`default_nettype wire
